// ----- rtl/mbrp_pkg.sv -----
// ----------------------------------------------------------------------------
// mbrp_pkg - shared types and constants of the MBR partition table parser
// Sector layout offsets, table geometry, result status codes, controller
// states and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mbrp_pkg;

	// most entries emitted per sector (4..8)
	localparam int ENTRY_LIMIT = 8;

	localparam int STD_TABLE_SIZE = 4;
	localparam int EXT_TABLE_SIZE = 8;
	localparam int STD_COUNT = (ENTRY_LIMIT < STD_TABLE_SIZE) ? ENTRY_LIMIT : STD_TABLE_SIZE;
	localparam int EXT_COUNT = (ENTRY_LIMIT < EXT_TABLE_SIZE) ? ENTRY_LIMIT : EXT_TABLE_SIZE;

	localparam logic [8:0] TAIL_BASE   = 9'h17C;
	localparam int         TAIL_DEPTH  = 132;
	localparam logic [8:0] MARK_LO_POS = 9'h17C;
	localparam logic [8:0] MARK_HI_POS = 9'h17D;
	localparam logic [8:0] SIG_LO_POS  = 9'd510;
	localparam logic [8:0] SIG_HI_POS  = 9'd511;

	// table bases as tail store indexes
	localparam logic [7:0] STD_BASE_IDX = 8'(9'h1BE - TAIL_BASE);
	localparam logic [7:0] EXT_BASE_IDX = 8'(9'h17E - TAIL_BASE);

	localparam logic [15:0] BOOT_SIGNATURE = 16'hAA55;
	localparam logic [15:0] EXT_MARKER     = 16'hA55A;

	typedef enum logic [1:0] {
		ST_STANDARD = 2'd0,
		ST_EXTENDED = 2'd1,
		ST_BAD_SIG  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_RECV,
		S_EVAL,
		S_READ,
		S_DRAIN,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic byte_accept;
		logic start_table;
		logic rd_en;
		logic load_bad;
		logic load_entry;
		logic next_entry;
	} ctrl_cmd_t;

	typedef struct packed {
		logic last_byte;
		logic sig_ok;
		logic rd_last;
		logic entry_last;
		logic out_free;
	} dp_stat_t;

endpackage

// ----- rtl/mbr_partition_table_parser_unit.sv -----
// ----------------------------------------------------------------------------
// mbr_partition_table_parser_unit - MBR partition table parser, top level
// Takes the 512 bytes of a first sector and emits decoded partition entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / sector_byte): one transaction per
//   sector byte, offset 0 first. Bytes are taken one per cycle while the
//   block is receiving; in_stall rises after the byte at offset 511 until the
//   table has been walked or the bad-signature result has been loaded.
//   Output channel (out_valid / out_stall / result fields): one transaction
//   per entry, last_entry set on the final one. A bad boot signature gives a
//   single transaction with status 2 and all entry fields zero.
// Table walk:
//   After byte 511 the signature is evaluated; then each entry takes 16
//   reads of the tail store, one read drain and one output load.
//   The result sits in an output register; once the last one is loaded the
//   next sector's bytes are taken while it waits.
// Reset: arst_n clears the byte offset, controller and output valid. The tail
//   store needs no clearing; each byte read is written earlier in the sector.
// Stall: out_stall holds the result register and pauses the table walk.
// ----------------------------------------------------------------------------
module mbr_partition_table_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  sector_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  boot_flags,
	output logic [7:0]  first_head,
	output logic [5:0]  first_sector,
	output logic [9:0]  first_cylinder,
	output logic [7:0]  type_id,
	output logic [7:0]  final_head,
	output logic [5:0]  final_sector,
	output logic [9:0]  final_cylinder,
	output logic [31:0] start_lba,
	output logic [31:0] length_sectors,
	output logic        last_entry
);

	mbrp_pkg::ctrl_cmd_t cmd;
	mbrp_pkg::dp_stat_t  stat;

	// sequencing: receive, check, walk entries
	mbrp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.cmd      (cmd)
	);

	// storage, decode and result register
	mbrp_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.sector_byte    (sector_byte),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.status         (status),
		.boot_flags     (boot_flags),
		.first_head     (first_head),
		.first_sector   (first_sector),
		.first_cylinder (first_cylinder),
		.type_id        (type_id),
		.final_head     (final_head),
		.final_sector   (final_sector),
		.final_cylinder (final_cylinder),
		.start_lba      (start_lba),
		.length_sectors (length_sectors),
		.last_entry     (last_entry)
	);

	assign in_stall = !cmd.in_ready;

endmodule

// ----- rtl/mbrp_ctrl.sv -----
// ----------------------------------------------------------------------------
// mbrp_ctrl - sequencing state machine
// Receives the sector, checks the signature, and on a good one walks the
// table entry by entry: sixteen store reads, a drain state, an output load.
// ----------------------------------------------------------------------------
module mbrp_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  mbrp_pkg::dp_stat_t  stat,
	output mbrp_pkg::ctrl_cmd_t cmd
);

	mbrp_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbrp_pkg::S_RECV;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mbrp_pkg::S_RECV: begin
				if (in_valid && stat.last_byte) state_d = mbrp_pkg::S_EVAL;
			end
			mbrp_pkg::S_EVAL: begin
				if (stat.out_free) begin
					state_d = stat.sig_ok ? mbrp_pkg::S_READ : mbrp_pkg::S_RECV;
				end
			end
			mbrp_pkg::S_READ: begin
				if (stat.rd_last) state_d = mbrp_pkg::S_DRAIN;
			end
			mbrp_pkg::S_DRAIN: begin
				state_d = mbrp_pkg::S_EMIT;
			end
			mbrp_pkg::S_EMIT: begin
				if (stat.out_free) begin
					state_d = stat.entry_last ? mbrp_pkg::S_RECV : mbrp_pkg::S_READ;
				end
			end
			default: state_d = mbrp_pkg::S_RECV;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			mbrp_pkg::S_RECV: begin
				cmd.in_ready    = 1'b1;
				cmd.byte_accept = in_valid;
			end
			mbrp_pkg::S_EVAL: begin
				cmd.load_bad    = stat.out_free && !stat.sig_ok;
				cmd.start_table = stat.out_free && stat.sig_ok;
			end
			mbrp_pkg::S_READ: begin
				cmd.rd_en = 1'b1;
			end
			mbrp_pkg::S_DRAIN: begin
			end
			mbrp_pkg::S_EMIT: begin
				cmd.load_entry = stat.out_free;
				cmd.next_entry = stat.out_free && !stat.entry_last;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ----- rtl/mbrp_dpath.sv -----
// ----------------------------------------------------------------------------
// mbrp_dpath - byte counter, tail store, entry assembly and result register
// Holds the 132-byte tail in a memory, captures signature and marker bytes
// as they stream past, and decodes each 16-byte entry into the result.
// ----------------------------------------------------------------------------
module mbrp_dpath (
	input  logic                clk,
	input  logic                arst_n,
	input  mbrp_pkg::ctrl_cmd_t cmd,
	output mbrp_pkg::dp_stat_t  stat,
	input  logic [7:0]          sector_byte,
	input  logic                out_stall,
	output logic                out_valid,
	output logic [1:0]          status,
	output logic [7:0]          boot_flags,
	output logic [7:0]          first_head,
	output logic [5:0]          first_sector,
	output logic [9:0]          first_cylinder,
	output logic [7:0]          type_id,
	output logic [7:0]          final_head,
	output logic [5:0]          final_sector,
	output logic [9:0]          final_cylinder,
	output logic [31:0]         start_lba,
	output logic [31:0]         length_sectors,
	output logic                last_entry
);

	logic [8:0]   pos_q;
	logic [7:0]   mark_lo_q, mark_hi_q, sig_lo_q, sig_hi_q;
	logic [7:0]   tail_mem [mbrp_pkg::TAIL_DEPTH];
	logic [7:0]   wr_idx;
	logic         in_tail;
	logic [7:0]   rd_addr;
	logic [7:0]   rdata_s1;
	logic         rd_vld_s1;
	logic [3:0]   rd_idx_q;
	logic [2:0]   entry_q;
	logic         ext_q;
	logic [127:0] entry_bytes_q;
	logic         out_valid_q;
	logic         out_free;
	logic [2:0]   last_idx;

	assign in_tail = (pos_q >= mbrp_pkg::TAIL_BASE);
	assign wr_idx  = 8'(pos_q - mbrp_pkg::TAIL_BASE);

	// byte offset and fixed-position captures
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (cmd.byte_accept) begin
			pos_q <= pos_q + 9'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.byte_accept) begin
			if (pos_q == mbrp_pkg::MARK_LO_POS) mark_lo_q <= sector_byte;
			if (pos_q == mbrp_pkg::MARK_HI_POS) mark_hi_q <= sector_byte;
			if (pos_q == mbrp_pkg::SIG_LO_POS)  sig_lo_q  <= sector_byte;
			if (pos_q == mbrp_pkg::SIG_HI_POS)  sig_hi_q  <= sector_byte;
		end
	end

	// tail store: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.byte_accept && in_tail) begin
			tail_mem[wr_idx] <= sector_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rdata_s1 <= tail_mem[rd_addr];
		end
	end

	assign rd_addr = (ext_q ? mbrp_pkg::EXT_BASE_IDX : mbrp_pkg::STD_BASE_IDX)
	                 + {1'b0, entry_q, 4'b0000} + {4'b0000, rd_idx_q};

	// table walk counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			entry_q   <= '0;
			ext_q     <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.start_table) begin
				rd_idx_q <= '0;
				entry_q  <= '0;
				ext_q    <= ({mark_hi_q, mark_lo_q} == mbrp_pkg::EXT_MARKER);
			end else begin
				if (cmd.rd_en)      rd_idx_q <= rd_idx_q + 4'd1;
				if (cmd.next_entry) entry_q  <= entry_q + 3'd1;
			end
		end
	end

	// entry bytes shift in low first: byte 0 ends at [7:0]
	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			entry_bytes_q <= {rdata_s1, entry_bytes_q[127:8]};
		end
	end

	assign last_idx = ext_q ? 3'(mbrp_pkg::EXT_COUNT - 1) : 3'(mbrp_pkg::STD_COUNT - 1);

	// result register
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_bad || cmd.load_entry) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_bad) begin
			status         <= mbrp_pkg::ST_BAD_SIG;
			boot_flags     <= '0;
			first_head     <= '0;
			first_sector   <= '0;
			first_cylinder <= '0;
			type_id        <= '0;
			final_head     <= '0;
			final_sector   <= '0;
			final_cylinder <= '0;
			start_lba      <= '0;
			length_sectors <= '0;
			last_entry     <= 1'b1;
		end else if (cmd.load_entry) begin
			status         <= ext_q ? mbrp_pkg::ST_EXTENDED : mbrp_pkg::ST_STANDARD;
			boot_flags     <= entry_bytes_q[7:0];
			first_head     <= entry_bytes_q[15:8];
			first_sector   <= entry_bytes_q[21:16];
			first_cylinder <= {entry_bytes_q[23:22], entry_bytes_q[31:24]};
			type_id        <= entry_bytes_q[39:32];
			final_head     <= entry_bytes_q[47:40];
			final_sector   <= entry_bytes_q[53:48];
			final_cylinder <= {entry_bytes_q[55:54], entry_bytes_q[63:56]};
			start_lba      <= entry_bytes_q[95:64];
			length_sectors <= entry_bytes_q[127:96];
			last_entry     <= (entry_q == last_idx);
		end
	end

	assign out_valid = out_valid_q;

	assign stat.last_byte  = (pos_q == mbrp_pkg::SIG_HI_POS);
	assign stat.sig_ok     = ({sig_hi_q, sig_lo_q} == mbrp_pkg::BOOT_SIGNATURE);
	assign stat.rd_last    = (rd_idx_q == 4'd15);
	assign stat.entry_last = (entry_q == last_idx);
	assign stat.out_free   = out_free;

endmodule

// ----- tb/sv/mbr_partition_table_parser_unit_tb.sv -----
// ----------------------------------------------------------------------------
// mbr_partition_table_parser_unit_tb - testbench of the MBR table parser
// Streams whole 512-byte sectors into the block. A local decoder mirrors the
// tail store and predicts every output transaction. A checker
// compares each output transaction field by field, in order. Both channels
// idle in random bursts, except in the closing full-rate phase.
// ----------------------------------------------------------------------------
module mbr_partition_table_parser_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Run bounds. The slowest legal run has every byte behind the longest
	// idle gap and every entry behind the longest stall, over ~37 sectors.
	localparam int CYCLE_LIMIT  = 900_000;
	// Sized for the longest (eight-entry) table walk, with room for stalls on top.
	localparam int DRAIN_CYCLES = 200;
	localparam int SECTOR_BYTES = 512;

	// Expected output transaction, one per partition entry (or bad signature).
	typedef struct packed {
		mbrp_pkg::status_t status;
		logic [7:0]  boot_flags;
		logic [7:0]  first_head;
		logic [5:0]  first_sector;
		logic [9:0]  first_cylinder;
		logic [7:0]  type_id;
		logic [7:0]  final_head;
		logic [5:0]  final_sector;
		logic [9:0]  final_cylinder;
		logic [31:0] start_lba;
		logic [31:0] length_sectors;
		logic        last_entry;
	} table_entry_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  sector_byte;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [7:0]  boot_flags;
	logic [7:0]  first_head;
	logic [5:0]  first_sector;
	logic [9:0]  first_cylinder;
	logic [7:0]  type_id;
	logic [7:0]  final_head;
	logic [5:0]  final_sector;
	logic [9:0]  final_cylinder;
	logic [31:0] start_lba;
	logic [31:0] length_sectors;
	logic        last_entry;

	// Decoder state: our own copy of the byte offset and the sector tail.
	logic [8:0]   rx_offset = '0;
	logic [7:0]   tail_img [mbrp_pkg::TAIL_DEPTH];
	table_entry_t entries_due [$];
	int           predicted_total = 0;

	// Sector image being built by a test, then streamed by send_sector.
	logic [7:0]   sector_buf [SECTOR_BYTES];

	int  mismatches  = 0;
	int  cycle_count = 0;
	bit  in_idle_en  = 1'b1;
	bit  out_idle_en = 1'b1;

	mbr_partition_table_parser_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.sector_byte    (sector_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.boot_flags     (boot_flags),
		.first_head     (first_head),
		.first_sector   (first_sector),
		.first_cylinder (first_cylinder),
		.type_id        (type_id),
		.final_head     (final_head),
		.final_sector   (final_sector),
		.final_cylinder (final_cylinder),
		.start_lba      (start_lba),
		.length_sectors (length_sectors),
		.last_entry     (last_entry)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// Watchdog: a hung handshake ends the run here.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Decoder: runs on the byte at offset 511 and queues what the block must
	// emit for the sector just completed.
	// ------------------------------------------------------------------------
	function automatic void decode_table();
		table_entry_t rec;
		logic [15:0]  sig;
		logic [15:0]  mark;
		bit           ext;
		logic [7:0]   base;
		int unsigned  count;
		logic [7:0]   e;
		sig  = {tail_img[8'(mbrp_pkg::SIG_HI_POS - mbrp_pkg::TAIL_BASE)],
		        tail_img[8'(mbrp_pkg::SIG_LO_POS - mbrp_pkg::TAIL_BASE)]};
		mark = {tail_img[8'(mbrp_pkg::MARK_HI_POS - mbrp_pkg::TAIL_BASE)],
		        tail_img[8'(mbrp_pkg::MARK_LO_POS - mbrp_pkg::TAIL_BASE)]};
		rec  = '0;
		if (sig != mbrp_pkg::BOOT_SIGNATURE) begin
			// no table: a lone status transaction, all entry fields zero
			rec.status     = mbrp_pkg::ST_BAD_SIG;
			rec.last_entry = 1'b1;
			entries_due.push_back(rec);
			predicted_total++;
		end else begin
			ext   = (mark == mbrp_pkg::EXT_MARKER);
			base  = ext ? mbrp_pkg::EXT_BASE_IDX : mbrp_pkg::STD_BASE_IDX;
			count = ext ? 8 : 4;
			if (count > mbrp_pkg::ENTRY_LIMIT)
				count = mbrp_pkg::ENTRY_LIMIT;
			for (int unsigned i = 0; i < count; i++) begin
				e = base + 8'(16 * i);
				rec.status         = ext ? mbrp_pkg::ST_EXTENDED : mbrp_pkg::ST_STANDARD;
				rec.boot_flags     = tail_img[e];
				rec.first_head     = tail_img[e + 8'd1];
				rec.first_sector   = tail_img[e + 8'd2][5:0];
				rec.first_cylinder = {tail_img[e + 8'd2][7:6], tail_img[e + 8'd3]};
				rec.type_id        = tail_img[e + 8'd4];
				rec.final_head     = tail_img[e + 8'd5];
				rec.final_sector   = tail_img[e + 8'd6][5:0];
				rec.final_cylinder = {tail_img[e + 8'd6][7:6], tail_img[e + 8'd7]};
				rec.start_lba      = {tail_img[e + 8'd11], tail_img[e + 8'd10],
				                      tail_img[e + 8'd9], tail_img[e + 8'd8]};
				rec.length_sectors = {tail_img[e + 8'd15], tail_img[e + 8'd14],
				                      tail_img[e + 8'd13], tail_img[e + 8'd12]};
				rec.last_entry     = (i + 1 == count);
				entries_due.push_back(rec);
				predicted_total++;
			end
		end
	endfunction

	// ------------------------------------------------------------------------
	// Sender: one input transaction. An optional idle burst comes first, so
	// in_valid only ever changes once per edge.
	// ------------------------------------------------------------------------
	task automatic send_byte(input logic [7:0] b);
		if (in_idle_en && $urandom_range(0, 23) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid    <= 1'b1;
		sector_byte <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// accepted on this edge: mirror it into the decoder
		if (rx_offset >= mbrp_pkg::TAIL_BASE)
			tail_img[8'(rx_offset - mbrp_pkg::TAIL_BASE)] = b;
		if (rx_offset == mbrp_pkg::SIG_HI_POS)
			decode_table();
		rx_offset = rx_offset + 9'd1;
	endtask

	task automatic send_sector();
		for (int i = 0; i < SECTOR_BYTES; i++)
			send_byte(sector_buf[9'(i)]);
	endtask

	// ------------------------------------------------------------------------
	// Sector builders
	// ------------------------------------------------------------------------
	// random bytes, with a bias toward 0x00 / 0xFF to hit field extremes
	task automatic fill_random();
		for (int i = 0; i < SECTOR_BYTES; i++) begin
			if ($urandom_range(0, 7) == 0)
				sector_buf[9'(i)] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
			else
				sector_buf[9'(i)] = 8'($urandom);
		end
	endtask

	task automatic put_signature(input logic [7:0] lo, input logic [7:0] hi);
		sector_buf[mbrp_pkg::SIG_LO_POS] = lo;
		sector_buf[mbrp_pkg::SIG_HI_POS] = hi;
	endtask

	task automatic put_marker(input logic [7:0] lo, input logic [7:0] hi);
		sector_buf[mbrp_pkg::MARK_LO_POS] = lo;
		sector_buf[mbrp_pkg::MARK_HI_POS] = hi;
	endtask

	task automatic fill_entry(input logic [8:0] offset, input logic [7:0] v);
		for (int i = 0; i < 16; i++)
			sector_buf[offset + 9'(i)] = v;
	endtask

	// kind 0..1: noise, 2..5: standard table (3..5 sometimes extension),
	// 6..8: extension table, 9: signature with one bit flipped
	task automatic make_sector(input int kind);
		logic [15:0] sig;
		logic [15:0] mark;
		fill_random();
		if (kind >= 2 && kind <= 8) begin
			put_signature(mbrp_pkg::BOOT_SIGNATURE[7:0], mbrp_pkg::BOOT_SIGNATURE[15:8]);
		end else if (kind == 9) begin
			sig = mbrp_pkg::BOOT_SIGNATURE ^ (16'h1 << $urandom_range(0, 15));
			put_signature(sig[7:0], sig[15:8]);
		end
		if ((kind >= 6 && kind <= 8) || (kind != 2 && $urandom_range(0, 3) == 0)) begin
			put_marker(mbrp_pkg::EXT_MARKER[7:0], mbrp_pkg::EXT_MARKER[15:8]);
		end else if (kind >= 2 && kind <= 5 && $urandom_range(0, 2) == 0) begin
			// marker one bit off: must fall back to the standard table
			mark = mbrp_pkg::EXT_MARKER ^ (16'h1 << $urandom_range(0, 15));
			put_marker(mark[7:0], mark[15:8]);
		end
	endtask

	// ------------------------------------------------------------------------
	// Checker: each accepted output transaction against the oldest entry due.
	// ------------------------------------------------------------------------
	task automatic check_field(input string name, input logic [31:0] exp_v,
	                           input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
			         $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		table_entry_t exp_e;
		if (arst_n && out_valid && !out_stall) begin
			if (entries_due.size() == 0) begin
				$display("%0t: unexpected transaction, expected none, actual status 0x%0h",
				         $time, status);
				mismatches++;
			end else begin
				exp_e = entries_due.pop_front();
				check_field("status", 32'(exp_e.status), 32'(status));
				check_field("boot_flags", 32'(exp_e.boot_flags), 32'(boot_flags));
				check_field("first_head", 32'(exp_e.first_head), 32'(first_head));
				check_field("first_sector", 32'(exp_e.first_sector), 32'(first_sector));
				check_field("first_cylinder", 32'(exp_e.first_cylinder),
				            32'(first_cylinder));
				check_field("type_id", 32'(exp_e.type_id), 32'(type_id));
				check_field("final_head", 32'(exp_e.final_head), 32'(final_head));
				check_field("final_sector", 32'(exp_e.final_sector), 32'(final_sector));
				check_field("final_cylinder", 32'(exp_e.final_cylinder),
				            32'(final_cylinder));
				check_field("start_lba", exp_e.start_lba, start_lba);
				check_field("length_sectors", exp_e.length_sectors, length_sectors);
				check_field("last_entry", 32'(exp_e.last_entry), 32'(last_entry));
			end
		end
	end

	// Receiver back-pressure: random stall bursts.
	initial begin
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_idle_en && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------
	// Four-entry table with extreme fields: all-zero entry, all-ones entry,
	// cylinder high bits taken from the sector byte, byte order of the LBAs.
	task automatic test_standard_table();
		fill_random();
		put_marker(8'h00, 8'h00);
		fill_entry(9'h1BE, 8'h00);
		fill_entry(9'h1CE, 8'hFF);
		sector_buf[9'h1DE] = 8'h80;
		sector_buf[9'h1DF] = 8'h01;
		sector_buf[9'h1E0] = 8'hC1;
		sector_buf[9'h1E1] = 8'h00;
		sector_buf[9'h1E2] = 8'h0C;
		sector_buf[9'h1E3] = 8'hFE;
		sector_buf[9'h1E4] = 8'h3F;
		sector_buf[9'h1E5] = 8'hFF;
		sector_buf[9'h1E6] = 8'h01;
		sector_buf[9'h1E7] = 8'h02;
		sector_buf[9'h1E8] = 8'h03;
		sector_buf[9'h1E9] = 8'h04;
		sector_buf[9'h1EA] = 8'h00;
		sector_buf[9'h1EB] = 8'h00;
		sector_buf[9'h1EC] = 8'h00;
		sector_buf[9'h1ED] = 8'h80;
		put_signature(mbrp_pkg::BOOT_SIGNATURE[7:0], mbrp_pkg::BOOT_SIGNATURE[15:8]);
		send_sector();
	endtask

	// Extension marker selects the eight-entry table at 0x17E.
	task automatic test_extended_table();
		fill_random();
		put_marker(mbrp_pkg::EXT_MARKER[7:0], mbrp_pkg::EXT_MARKER[15:8]);
		fill_entry(9'h17E, 8'h00);
		fill_entry(9'h1EE, 8'hFF);
		put_signature(mbrp_pkg::BOOT_SIGNATURE[7:0], mbrp_pkg::BOOT_SIGNATURE[15:8]);
		send_sector();
	endtask

	// Broken signature: low byte off, high byte off, bytes swapped (the last
	// with the extension marker present, which must not matter).
	task automatic test_bad_signature();
		make_sector(2);
		put_signature(8'h54, 8'hAA);
		send_sector();
		make_sector(2);
		put_signature(8'h55, 8'hAB);
		send_sector();
		make_sector(6);
		put_signature(8'hAA, 8'h55);
		send_sector();
	endtask

	// Marker near misses fall back to the four-entry table.
	task automatic test_marker_near_miss();
		make_sector(2);
		put_marker(8'h5A, 8'hA4);
		send_sector();
		make_sector(2);
		put_marker(8'hA5, 8'h5A);
		send_sector();
	endtask

	// Sender holds off until every due entry has come out, then resumes.
	task automatic test_drain_pause();
		make_sector(6);
		send_sector();
		in_valid <= 1'b0;
		do @(posedge clk); while (entries_due.size() != 0);
		make_sector(3);
		send_sector();
	endtask

	// Mostly well-formed sectors with random content, some noise.
	task automatic test_random_sectors();
		int start_total;
		int sectors;
		start_total = predicted_total;
		sectors     = 0;
		while ((predicted_total - start_total) < 48 && sectors < 24) begin
			make_sector($urandom_range(0, 9));
			send_sector();
			sectors++;
		end
	endtask

	// Closing phase: no idling on either side, sectors back to back.
	task automatic test_full_rate();
		in_idle_en  = 1'b0;
		out_idle_en = 1'b0;
		make_sector(7);
		send_sector();
		make_sector(4);
		send_sector();
		make_sector(0);
		send_sector();
		make_sector(8);
		send_sector();
	endtask

	// ------------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		sector_byte = 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_standard_table();
		test_extended_table();
		test_bad_signature();
		test_marker_near_miss();
		test_drain_pause();
		test_random_sectors();
		test_full_rate();

		// all bytes are in; let the last table walk finish
		in_valid <= 1'b0;
		do @(posedge clk); while (entries_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && entries_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
